// ----- src/clkdfs_pkg.sv -----
// shared widths, register codes and types for the clock divider factor search
package clkdfs_pkg;

	localparam int RATE_W            = 32;
	localparam int TGT_W             = 33;
	localparam int DIFF_W            = 34;
	localparam int DELTA_W           = 31;
	localparam int CODE_W            = 8;
	localparam int SHIFT_W           = 3;
	localparam int MFW_W             = 4;
	localparam int PFW_W             = 2;
	localparam int M_W               = 9;
	localparam int BYTE_W            = 8;
	localparam int TABLE_ENTRIES_DEF = 8;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;

	// a deviation at or above this is never taken
	localparam logic [DELTA_W-1:0] NO_TAKE_LIMIT = 31'd2000000000;

	// widest m field honored, and the largest linear divider it allows
	localparam logic [MFW_W-1:0] MFW_LIMIT = 4'd8;
	localparam logic [M_W-1:0]   M_LIMIT   = 9'd256;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_M_FIELD_WIDTH       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_P_FIELD_WIDTH       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_DIVIDER_TABLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_TABLE_WORDS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_SELECT_ENABLE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_THRESHOLD      = 3'd5;

	// register reset values
	localparam logic [MFW_W-1:0] RST_M_FIELD_WIDTH = 4'd4;
	localparam logic [PFW_W-1:0] RST_P_FIELD_WIDTH = 2'd2;

	// best candidate so far, as kept by the evaluator
	typedef struct packed {
		logic               exact;
		logic [CODE_W-1:0]  code;
		logic [SHIFT_W-1:0] shift;
		logic [RATE_W-1:0]  rate;
	} eval_res_t;

endpackage

// ----- src/clkdfs_serial_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module clkdfs_serial_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [clkdfs_pkg::RATE_W-1:0] dividend,
	input  logic [clkdfs_pkg::TGT_W-1:0]  divisor,
	output logic                          done,
	output logic [clkdfs_pkg::RATE_W-1:0] quotient
);

	localparam int CNT_W = $clog2(clkdfs_pkg::RATE_W);

	logic [CNT_W-1:0]                busy_cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [clkdfs_pkg::RATE_W-1:0]   dq_q;
	logic [clkdfs_pkg::TGT_W-1:0]    rem_q;
	logic [clkdfs_pkg::TGT_W-1:0]    dvs_q;
	logic [clkdfs_pkg::TGT_W:0]      trial;
	logic [clkdfs_pkg::TGT_W:0]      diff;
	logic                            ge;

	// partial remainder with the next dividend bit shifted in
	assign trial = {rem_q, dq_q[clkdfs_pkg::RATE_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= '0;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			dq_q       <= '0;
			rem_q      <= '0;
			dvs_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dq_q       <= dividend;
				rem_q      <= '0;
				dvs_q      <= divisor;
				busy_cnt_q <= CNT_W'(clkdfs_pkg::RATE_W - 1);
				busy_q     <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[clkdfs_pkg::TGT_W-1:0] : trial[clkdfs_pkg::TGT_W-1:0];
				dq_q  <= {dq_q[clkdfs_pkg::RATE_W-2:0], ge};
				if (busy_cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_cnt_q <= busy_cnt_q - CNT_W'(1);
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ----- src/clkdfs_cand_eval.sv -----
// two-stage candidate evaluator: distance to target, then best-so-far update
module clkdfs_cand_eval (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  logic                           go,
	input  logic [clkdfs_pkg::TGT_W-1:0]   target,
	input  logic [clkdfs_pkg::RATE_W-1:0]  cand,
	input  logic [clkdfs_pkg::CODE_W-1:0]  code,
	input  logic [clkdfs_pkg::SHIFT_W-1:0] shift,
	output clkdfs_pkg::eval_res_t          res
);

	logic                            vld_s1;
	logic [clkdfs_pkg::DIFF_W-1:0]   absd_s1;
	logic [clkdfs_pkg::RATE_W-1:0]   cand_s1;
	logic [clkdfs_pkg::CODE_W-1:0]   code_s1;
	logic [clkdfs_pkg::SHIFT_W-1:0]  shift_s1;
	logic [clkdfs_pkg::DELTA_W-1:0]  best_delta_q;
	clkdfs_pkg::eval_res_t           res_q;
	logic [clkdfs_pkg::DIFF_W-1:0]   dpos;
	logic [clkdfs_pkg::DIFF_W-1:0]   dneg;
	logic [clkdfs_pkg::DIFF_W-1:0]   absd;

	// both differences at once, sign of the first picks
	assign dpos = clkdfs_pkg::DIFF_W'(target) - clkdfs_pkg::DIFF_W'(cand);
	assign dneg = clkdfs_pkg::DIFF_W'(cand) - clkdfs_pkg::DIFF_W'(target);
	assign absd = dpos[clkdfs_pkg::DIFF_W-1] ? dneg : dpos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			absd_s1      <= '0;
			cand_s1      <= '0;
			code_s1      <= '0;
			shift_s1     <= '0;
			best_delta_q <= clkdfs_pkg::NO_TAKE_LIMIT;
			res_q        <= '0;
		end else begin
			vld_s1 <= go;
			if (go) begin
				absd_s1  <= absd;
				cand_s1  <= cand;
				code_s1  <= code;
				shift_s1 <= shift;
			end
			if (clr) begin
				best_delta_q <= clkdfs_pkg::NO_TAKE_LIMIT;
				res_q        <= '0;
			end else if (vld_s1) begin
				if (absd_s1 == '0) begin
					res_q.exact <= 1'b1;
					res_q.rate  <= cand_s1;
					res_q.code  <= code_s1;
					res_q.shift <= shift_s1;
				end else if (absd_s1 < clkdfs_pkg::DIFF_W'(best_delta_q)) begin
					// strict compare keeps the first of equal candidates
					best_delta_q <= absd_s1[clkdfs_pkg::DELTA_W-1:0];
					res_q.rate   <= cand_s1;
					res_q.code   <= code_s1;
					res_q.shift  <= shift_s1;
				end
			end
		end
	end

	assign res = res_q;

endmodule

// ----- src/clock_divider_factor_search_unit.sv -----
// top level of the clock divider factor search: registers, sequencer and result beat
// search: shift-only steps down the shift field; table search does one serial divide per entry,
//   then weighs each shift of that quotient; linear search first divides parent by target, then
//   does one or two divides (div and div+1) per shift; the serial divider sets the pace
// one item at a time; the next item is taken while a result beat waits in the output register
// reset: asynchronous, clears the sequencer and output valid, registers take their defaults
module clock_divider_factor_search_unit #(
	parameter int TABLE_ENTRIES = clkdfs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [clkdfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clkdfs_pkg::CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [clkdfs_pkg::RATE_W-1:0]     target_rate,
	input  logic [clkdfs_pkg::RATE_W-1:0]     parent_rate,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [clkdfs_pkg::CODE_W-1:0]     m_code,
	output logic [clkdfs_pkg::SHIFT_W-1:0]    p_shift,
	output logic [clkdfs_pkg::RATE_W-1:0]     achieved_rate,
	output logic                              mode_bit
);

	// only the table bytes that are ever scanned are stored
	localparam int TBL_W = TABLE_ENTRIES * clkdfs_pkg::BYTE_W;
	localparam int ENT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SHIFT,
		ST_LIN_QDIV,
		ST_LIN_P,
		ST_LIN_MDIV,
		ST_TBL_ENTRY,
		ST_TBL_DIV,
		ST_EVAL1,
		ST_EVAL2,
		ST_CHECK,
		ST_DONE
	} state_t;

	// configuration registers
	logic [clkdfs_pkg::MFW_W-1:0]   m_fw_q;
	logic [clkdfs_pkg::PFW_W-1:0]   p_fw_q;
	logic                           use_tbl_q;
	logic [TBL_W-1:0]               tbl_q;
	logic                           mode_en_q;
	logic [clkdfs_pkg::RATE_W-1:0]  thr_q;

	// sequencer and item state
	state_t                          state_q;
	logic [clkdfs_pkg::TGT_W-1:0]    tgt_q;
	logic [clkdfs_pkg::RATE_W-1:0]   par_q;
	logic                            mode_q;
	logic                            special_q;
	logic [clkdfs_pkg::SHIFT_W-1:0]  sp_shift_q;
	logic [clkdfs_pkg::SHIFT_W-1:0]  p_q;
	logic [clkdfs_pkg::RATE_W-1:0]   quo_q;
	logic [clkdfs_pkg::M_W-1:0]      m_q;
	logic                            second_q;
	logic [ENT_W-1:0]                ent_q;
	logic [TBL_W-1:0]                tblsh_q;
	logic                            div_start_q;
	logic                            eval_go_q;

	// result beat register
	logic                            out_valid_q;
	logic [clkdfs_pkg::CODE_W-1:0]   m_code_q;
	logic [clkdfs_pkg::SHIFT_W-1:0]  p_shift_q;
	logic [clkdfs_pkg::RATE_W-1:0]   rate_q;
	logic                            mode_out_q;

	// derived control
	logic                            accept;
	logic                            no_fields;
	logic                            mode_hit;
	logic [clkdfs_pkg::SHIFT_W-1:0]  p_max;
	logic [clkdfs_pkg::M_W-1:0]      m_max;
	logic [clkdfs_pkg::RATE_W-1:0]   div_v;
	logic                            div_over;
	logic [clkdfs_pkg::BYTE_W-1:0]   tbl_byte;
	logic                            shift_above;

	// divider and evaluator hookup
	logic [clkdfs_pkg::TGT_W-1:0]    div_dvs;
	logic                            div_done;
	logic [clkdfs_pkg::RATE_W-1:0]   div_quo;
	logic [clkdfs_pkg::RATE_W-1:0]   ev_cand;
	logic [clkdfs_pkg::CODE_W-1:0]   ev_code;
	clkdfs_pkg::eval_res_t           ev_res;

	// ---------------------------------------------------------------
	// configuration port: always ready, writes beyond the list are dropped
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_fw_q    <= clkdfs_pkg::RST_M_FIELD_WIDTH;
			p_fw_q    <= clkdfs_pkg::RST_P_FIELD_WIDTH;
			use_tbl_q <= 1'b0;
			tbl_q     <= '0;
			mode_en_q <= 1'b0;
			thr_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				clkdfs_pkg::CFG_M_FIELD_WIDTH: begin
					m_fw_q <= cfg_data[clkdfs_pkg::MFW_W-1:0];
				end
				clkdfs_pkg::CFG_P_FIELD_WIDTH: begin
					p_fw_q <= cfg_data[clkdfs_pkg::PFW_W-1:0];
				end
				clkdfs_pkg::CFG_USE_DIVIDER_TABLE: begin
					use_tbl_q <= cfg_data[0];
				end
				clkdfs_pkg::CFG_DIVIDER_TABLE_WORDS: begin
					tbl_q <= cfg_data[TBL_W-1:0];
				end
				clkdfs_pkg::CFG_MODE_SELECT_ENABLE: begin
					mode_en_q <= cfg_data[0];
				end
				clkdfs_pkg::CFG_MODE_THRESHOLD: begin
					thr_q <= cfg_data[clkdfs_pkg::RATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// decode of the configuration and the current search point
	// ---------------------------------------------------------------
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign no_fields = (m_fw_q == '0) && (p_fw_q == '0);
	// doubling mode never applies when there is nothing to search
	assign mode_hit  = !no_fields && mode_en_q && (target_rate >= thr_q);

	// p_max = 2^p_fw - 1
	assign p_max = clkdfs_pkg::SHIFT_W'((4'd1 << p_fw_q) - 4'd1);
	// m field wider than 8 bits is clamped, so m never exceeds 256
	assign m_max = (m_fw_q > clkdfs_pkg::MFW_LIMIT) ? clkdfs_pkg::M_LIMIT
	                                                : clkdfs_pkg::M_W'(9'd1 << m_fw_q);

	// linear candidate base: (parent / target) >> p
	assign div_v    = quo_q >> p_q;
	assign div_over = div_v > clkdfs_pkg::RATE_W'(m_max);

	// table is walked from the low byte by shifting it down
	assign tbl_byte = tblsh_q[clkdfs_pkg::BYTE_W-1:0];

	// shift-only search: does this shift still leave the rate above target
	assign shift_above = clkdfs_pkg::TGT_W'(par_q >> p_q) > tgt_q;

	// first divide of a linear search is parent / target, all others parent / m
	assign div_dvs = (state_q == ST_LIN_QDIV) ? tgt_q : clkdfs_pkg::TGT_W'(m_q);

	// candidate rate and code for the evaluator, stable through ST_EVAL1
	assign ev_cand = div_quo >> p_q;
	assign ev_code = use_tbl_q ? clkdfs_pkg::CODE_W'(ent_q)
	                           : clkdfs_pkg::CODE_W'(m_q - clkdfs_pkg::M_W'(1));

	clkdfs_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (par_q),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	clkdfs_cand_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept),
		.go     (eval_go_q),
		.target (tgt_q),
		.cand   (ev_cand),
		.code   (ev_code),
		.shift  (p_q),
		.res    (ev_res)
	);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tgt_q       <= '0;
			par_q       <= '0;
			mode_q      <= 1'b0;
			special_q   <= 1'b0;
			sp_shift_q  <= '0;
			p_q         <= '0;
			quo_q       <= '0;
			m_q         <= '0;
			second_q    <= 1'b0;
			ent_q       <= '0;
			tblsh_q     <= '0;
			div_start_q <= 1'b0;
			eval_go_q   <= 1'b0;
			out_valid_q <= 1'b0;
			m_code_q    <= '0;
			p_shift_q   <= '0;
			rate_q      <= '0;
			mode_out_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			eval_go_q   <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						par_q   <= parent_rate;
						mode_q  <= mode_hit;
						// doubled target kept at 33 bits so it never wraps
						tgt_q   <= mode_hit ? {target_rate, 1'b0} : {1'b0, target_rate};
						state_q <= ST_DISPATCH;
					end
				end

				ST_DISPATCH: begin
					if (no_fields) begin
						special_q  <= 1'b1;
						sp_shift_q <= '0;
						state_q    <= ST_DONE;
					end else if (m_fw_q == '0) begin
						// shift-only: scan from p_max - 1 down
						special_q <= 1'b1;
						p_q       <= p_max - clkdfs_pkg::SHIFT_W'(1);
						state_q   <= ST_SHIFT;
					end else if (use_tbl_q) begin
						special_q <= 1'b0;
						ent_q     <= '0;
						tblsh_q   <= tbl_q;
						state_q   <= ST_TBL_ENTRY;
					end else begin
						special_q <= 1'b0;
						// zero target means a saturated quotient: nothing fits
						if (tgt_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							p_q         <= p_max;
							div_start_q <= 1'b1;
							state_q     <= ST_LIN_QDIV;
						end
					end
				end

				ST_SHIFT: begin
					if (shift_above) begin
						sp_shift_q <= p_q + clkdfs_pkg::SHIFT_W'(1);
						state_q    <= ST_DONE;
					end else if (p_q == '0) begin
						sp_shift_q <= '0;
						state_q    <= ST_DONE;
					end else begin
						p_q <= p_q - clkdfs_pkg::SHIFT_W'(1);
					end
				end

				ST_LIN_QDIV: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= ST_LIN_P;
					end
				end

				ST_LIN_P: begin
					if (div_over) begin
						// neither div nor div+1 fits the field at this shift
						if (p_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							p_q <= p_q - clkdfs_pkg::SHIFT_W'(1);
						end
					end else begin
						// a zero divider is skipped, go straight to div+1
						if (div_v == '0) begin
							m_q      <= clkdfs_pkg::M_W'(1);
							second_q <= 1'b1;
						end else begin
							m_q      <= div_v[clkdfs_pkg::M_W-1:0];
							second_q <= 1'b0;
						end
						div_start_q <= 1'b1;
						state_q     <= ST_LIN_MDIV;
					end
				end

				ST_LIN_MDIV: begin
					if (div_done) begin
						eval_go_q <= 1'b1;
						state_q   <= ST_EVAL1;
					end
				end

				ST_TBL_ENTRY: begin
					// table ends at the entry limit or at the first zero byte
					if ((ent_q == ENT_W'(TABLE_ENTRIES)) || (tbl_byte == '0)) begin
						state_q <= ST_DONE;
					end else begin
						m_q         <= clkdfs_pkg::M_W'(tbl_byte);
						p_q         <= p_max;
						div_start_q <= 1'b1;
						state_q     <= ST_TBL_DIV;
					end
				end

				ST_TBL_DIV: begin
					if (div_done) begin
						eval_go_q <= 1'b1;
						state_q   <= ST_EVAL1;
					end
				end

				ST_EVAL1: begin
					state_q <= ST_EVAL2;
				end

				ST_EVAL2: begin
					state_q <= ST_CHECK;
				end

				ST_CHECK: begin
					if (ev_res.exact) begin
						state_q <= ST_DONE;
					end else if (use_tbl_q) begin
						// same quotient, next lower shift, else next entry
						if (p_q == '0) begin
							ent_q   <= ent_q + ENT_W'(1);
							tblsh_q <= tblsh_q >> clkdfs_pkg::BYTE_W;
							state_q <= ST_TBL_ENTRY;
						end else begin
							p_q       <= p_q - clkdfs_pkg::SHIFT_W'(1);
							eval_go_q <= 1'b1;
							state_q   <= ST_EVAL1;
						end
					end else if (!second_q && (m_q < m_max)) begin
						m_q         <= m_q + clkdfs_pkg::M_W'(1);
						second_q    <= 1'b1;
						div_start_q <= 1'b1;
						state_q     <= ST_LIN_MDIV;
					end else if (p_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						p_q     <= p_q - clkdfs_pkg::SHIFT_W'(1);
						state_q <= ST_LIN_P;
					end
				end

				ST_DONE: begin
					// hold here until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						mode_out_q  <= mode_q;
						if (special_q) begin
							m_code_q  <= '0;
							p_shift_q <= sp_shift_q;
							rate_q    <= par_q >> sp_shift_q;
						end else begin
							m_code_q  <= ev_res.code;
							p_shift_q <= ev_res.shift;
							rate_q    <= ev_res.rate;
						end
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign m_code        = m_code_q;
	assign p_shift       = p_shift_q;
	assign achieved_rate = rate_q;
	assign mode_bit      = mode_out_q;

`ifndef SYNTHESIS
	// an accepted request keeps the request side stalled on the next cycle
	a_accept_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request side not stalled after accept");

	// exact flag can only come from an issued candidate, registered through vld_s1 and then res_q
	a_exact_from_go: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ev_res.exact) |-> $past(eval_go_q, 2))
		else $error("exact match without an issued candidate");

	// divider completion is only seen while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_LIN_QDIV || state_q == ST_LIN_MDIV ||
		              state_q == ST_TBL_DIV))
		else $error("divider finished outside a wait state");

	// a result beat appears only when the search has finished
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the done state");
`endif

endmodule

// ----- tb/sv/clock_divider_factor_search_checker.sv -----
`timescale 1ns / 100ps
// checker for the clock divider factor search: mirrors the registers, predicts and compares beats
module clock_divider_factor_search_checker
	import clkdfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [RATE_W-1:0]     target_rate,
	input  logic [RATE_W-1:0]     parent_rate,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [CODE_W-1:0]     m_code,
	input  logic [SHIFT_W-1:0]    p_shift,
	input  logic [RATE_W-1:0]     achieved_rate,
	input  logic                  mode_bit,
	input  logic                  run_done,
	output int                    picks_waiting,
	output int                    fail_count
);

	localparam longint NO_TAKE_DEV = 64'd2000000000;

	typedef struct packed {
		logic [RATE_W-1:0]  target;
		logic [RATE_W-1:0]  parent;
		logic [CODE_W-1:0]  code;
		logic [SHIFT_W-1:0] shift;
		logic [RATE_W-1:0]  rate;
		logic               mode;
	} factor_pick_t;

	typedef struct {
		longint unsigned rate;
		int unsigned     code;
		int unsigned     shift;
	} trial_t;

	// register mirror
	logic [MFW_W-1:0]      mfw_q;
	logic [PFW_W-1:0]      pfw_q;
	logic                  use_tab_q;
	logic [CFG_DATA_W-1:0] tab_q;
	logic                  mse_q;
	logic [RATE_W-1:0]     thr_q;

	factor_pick_t picks_q[$];
	int           mismatches = 0;
	bit           flushed    = 1'b0;

	assign fail_count = mismatches;

	// candidates are listed in scan order, then weighed; an exact hit ends the scan
	function automatic factor_pick_t search_factors(input logic [RATE_W-1:0] tgt_in,
		input logic [RATE_W-1:0] par_in);
		factor_pick_t    pick;
		trial_t          trials[$];
		trial_t          tr;
		logic [TGT_W-1:0] goal;
		longint unsigned par, quo, base, m, m_max, entry;
		longint          best_dev, dev;
		int              p_max, q, i, p, k;
		pick = '0;
		pick.target = tgt_in;
		pick.parent = par_in;
		par = par_in;
		p_max = (1 << pfw_q) - 1;
		if (mfw_q == 0 && pfw_q == 0) begin
			pick.rate = par_in;
			return pick;
		end
		goal = tgt_in;
		if (mse_q && tgt_in >= thr_q) begin
			pick.mode = 1'b1;
			goal = {tgt_in, 1'b0};
		end
		if (mfw_q == 0) begin
			for (q = p_max - 1; q >= 0; q--) begin
				if ((par >> q) > goal)
					break;
			end
			q++;
			pick.shift = q;
			pick.rate = par >> q;
			return pick;
		end
		if (use_tab_q) begin
			for (i = 0; i < TABLE_ENTRIES_DEF && i < 8; i++) begin
				entry = (tab_q >> (8 * i)) & 64'hFF;
				if (entry == 0)
					break;
				for (p = p_max; p >= 0; p--) begin
					tr.rate = (par / entry) >> p;
					tr.code = i;
					tr.shift = p;
					trials.push_back(tr);
				end
			end
		end else begin
			m_max = 64'd1 << ((mfw_q > MFW_LIMIT) ? MFW_LIMIT : mfw_q);
			quo = (goal != 0) ? par / goal : '1;
			for (p = p_max; p >= 0; p--) begin
				base = quo >> p;
				for (k = 0; k < 2; k++) begin
					m = base + k;
					if (m < base || m > m_max)
						break;
					if (m == 0)
						continue;
					tr.rate = (par / m) >> p;
					tr.code = m - 1;
					tr.shift = p;
					trials.push_back(tr);
				end
			end
		end
		best_dev = NO_TAKE_DEV;
		foreach (trials[j]) begin
			dev = longint'(goal) - longint'(trials[j].rate);
			if (dev == 0) begin
				pick.code = trials[j].code;
				pick.shift = trials[j].shift;
				pick.rate = trials[j].rate;
				return pick;
			end
			if (dev < 0)
				dev = -dev;
			if (dev < best_dev) begin
				best_dev = dev;
				pick.code = trials[j].code;
				pick.shift = trials[j].shift;
				pick.rate = trials[j].rate;
			end
		end
		return pick;
	endfunction

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		factor_pick_t want;
		if (!arst_n) begin
			mfw_q <= RST_M_FIELD_WIDTH;
			pfw_q <= RST_P_FIELD_WIDTH;
			use_tab_q <= 1'b0;
			tab_q <= '0;
			mse_q <= 1'b0;
			thr_q <= '0;
			picks_q.delete();
			picks_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_M_FIELD_WIDTH:       mfw_q <= cfg_data[MFW_W-1:0];
					CFG_P_FIELD_WIDTH:       pfw_q <= cfg_data[PFW_W-1:0];
					CFG_USE_DIVIDER_TABLE:   use_tab_q <= cfg_data[0];
					CFG_DIVIDER_TABLE_WORDS: tab_q <= cfg_data;
					CFG_MODE_SELECT_ENABLE:  mse_q <= cfg_data[0];
					CFG_MODE_THRESHOLD:      thr_q <= cfg_data[RATE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				picks_q.push_back(search_factors(target_rate, parent_rate));
			if (out_valid && !out_stall) begin
				if (picks_q.size() == 0) begin
					report("result beat with no request waiting");
				end else begin
					want = picks_q.pop_front();
					if (m_code !== want.code)
						report($sformatf("m_code %0d, want %0d (target %0d parent %0d)",
							m_code, want.code, want.target, want.parent));
					if (p_shift !== want.shift)
						report($sformatf("p_shift %0d, want %0d (target %0d parent %0d)",
							p_shift, want.shift, want.target, want.parent));
					if (achieved_rate !== want.rate)
						report($sformatf("achieved_rate %0d, want %0d (target %0d parent %0d)",
							achieved_rate, want.rate, want.target, want.parent));
					if (mode_bit !== want.mode)
						report($sformatf("mode_bit %0d, want %0d (target %0d parent %0d)",
							mode_bit, want.mode, want.target, want.parent));
				end
			end
			if (run_done && !flushed) begin
				flushed = 1'b1;
				if (picks_q.size() != 0)
					report($sformatf("%0d result beats never arrived", picks_q.size()));
			end
			picks_waiting <= picks_q.size();
		end
	end

endmodule

// ----- tb/sv/clock_divider_factor_search_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the clock divider factor search: clock, reset, stimulus and verdict
module clock_divider_factor_search_unit_tb;
	import clkdfs_pkg::*;

	localparam int RANDOM_ITEMS   = 1000;
	localparam int HOLDOFF_CYCLES = 3000;
	// tail wait after the drain, for any beat still in flight
	localparam int TAIL_CYCLES    = 700;
	localparam int DRAIN_LIMIT    = 20000;

	// indexes past the last register, written once to see that they are ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [RATE_W-1:0]     target_rate = '0;
	logic [RATE_W-1:0]     parent_rate = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [CODE_W-1:0]     m_code;
	logic [SHIFT_W-1:0]    p_shift;
	logic [RATE_W-1:0]     achieved_rate;
	logic                  mode_bit;
	logic                  run_done    = 1'b0;
	int                    picks_waiting;
	int                    fail_count;

	// idle rates in percent for the sender and the receiver
	int unsigned idle_pct  = 22;
	int unsigned stall_pct = 69;

	// long receiver hold-off, fired once by the stimulus
	logic holdoff_go    = 1'b0;
	logic holdoff_spent = 1'b0;
	int   holdoff_left  = 0;

	// what the stimulus last wrote, used to aim targets at reachable rates
	logic [MFW_W-1:0]      knob_mfw   = RST_M_FIELD_WIDTH;
	logic [PFW_W-1:0]      knob_pfw   = RST_P_FIELD_WIDTH;
	logic                  knob_tab   = 1'b0;
	logic [CFG_DATA_W-1:0] knob_words = '0;
	logic                  knob_mse   = 1'b0;
	logic [RATE_W-1:0]     knob_thr   = '0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	clock_divider_factor_search_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.target_rate   (target_rate),
		.parent_rate   (parent_rate),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.m_code        (m_code),
		.p_shift       (p_shift),
		.achieved_rate (achieved_rate),
		.mode_bit      (mode_bit)
	);

	clock_divider_factor_search_checker factor_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.target_rate   (target_rate),
		.parent_rate   (parent_rate),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.m_code        (m_code),
		.p_shift       (p_shift),
		.achieved_rate (achieved_rate),
		.mode_bit      (mode_bit),
		.run_done      (run_done),
		.picks_waiting (picks_waiting),
		.fail_count    (fail_count)
	);

	// receiver: random stall per cycle, except during the one long hold-off
	always @(posedge clk) begin
		if (holdoff_left != 0) begin
			out_stall <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_go && !holdoff_spent) begin
			// result register fills, then the block stalls its request side
			out_stall <= 1'b1;
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_spent <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// one beat on the config channel; valid stays up so back-to-back writes need no gap
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// half the time, garbage above the register width, which the block must drop
	function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] val,
		input int width);
		logic [CFG_DATA_W-1:0] junk;
		junk = {$urandom, $urandom};
		if ($urandom_range(1))
			return val;
		return (junk << width) | val;
	endfunction

	// stop offering and wait until every predicted result beat has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (picks_waiting != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic [MFW_W-1:0] mfw, input logic [PFW_W-1:0] pfw,
		input logic tab_on, input logic [CFG_DATA_W-1:0] words, input logic mse,
		input logic [RATE_W-1:0] thr);
		wait_idle();
		write_reg(CFG_M_FIELD_WIDTH, with_junk(mfw, MFW_W));
		write_reg(CFG_P_FIELD_WIDTH, with_junk(pfw, PFW_W));
		write_reg(CFG_USE_DIVIDER_TABLE, with_junk(tab_on, 1));
		write_reg(CFG_DIVIDER_TABLE_WORDS, words);
		write_reg(CFG_MODE_SELECT_ENABLE, with_junk(mse, 1));
		write_reg(CFG_MODE_THRESHOLD, with_junk(thr, RATE_W));
		cfg_valid <= 1'b0;
		knob_mfw = mfw;
		knob_pfw = pfw;
		knob_tab = tab_on;
		knob_words = words;
		knob_mse = mse;
		knob_thr = thr;
	endtask

	// optional idle gap, then hold the request beat until it is taken
	task automatic send_item(input logic [RATE_W-1:0] tgt, input logic [RATE_W-1:0] par);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			// mostly short gaps, now and then one spanning a whole search
			gap = ($urandom_range(9) == 0) ? $urandom_range(1, 700) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		target_rate <= tgt;
		parent_rate <= par;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic logic [RATE_W-1:0] extreme_value();
		case ($urandom_range(4))
			0: return 32'd1;
			1: return 32'd2;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic random_settings();
		logic [MFW_W-1:0]      mfw;
		logic [CFG_DATA_W-1:0] words;
		logic [RATE_W-1:0]     thr;
		int                    i;
		case ($urandom_range(7))
			0: mfw = 4'd0;
			1: mfw = MFW_LIMIT;
			2: mfw = $urandom_range(9, 15);
			default: mfw = $urandom_range(1, 8);
		endcase
		// table bytes: some zero to end the table early, many small dividers
		for (i = 0; i < 8; i++) begin
			case ($urandom_range(9))
				0: words[8*i +: 8] = 8'd0;
				1: words[8*i +: 8] = 8'hFF;
				2, 3, 4, 5: words[8*i +: 8] = $urandom_range(1, 16);
				default: words[8*i +: 8] = $urandom_range(1, 255);
			endcase
		end
		if ($urandom_range(7) == 0)
			words = {$urandom, $urandom};
		case ($urandom_range(3))
			0: thr = '0;
			1: thr = '1;
			default: thr = $urandom;
		endcase
		apply_settings(mfw, $urandom_range(3), ($urandom_range(2) == 0), words,
			$urandom_range(1), thr);
	endtask

	// half the targets sit on or next to a rate the current settings can reach
	task automatic send_random_item();
		logic [RATE_W-1:0] tgt, par;
		longint unsigned   m, reach;
		longint            aim;
		int                p, mw, entries;
		tgt = $urandom;
		par = $urandom;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				if ($urandom_range(3) == 0)
					par = $urandom_range(1, 1 << 16);
				if (par == 0)
					par = 1;
				p = $urandom_range(0, (1 << knob_pfw) - 1);
				if (knob_tab) begin
					entries = 0;
					while (entries < 8 && knob_words[8*entries +: 8] != 0)
						entries++;
					m = (entries != 0) ? knob_words[8*$urandom_range(0, entries - 1) +: 8] : 1;
				end else begin
					mw = (knob_mfw > MFW_LIMIT) ? MFW_LIMIT : knob_mfw;
					m = $urandom_range(1, (1 << mw) + 1);
				end
				reach = (par / m) >> p;
				aim = longint'(reach) + longint'($urandom_range(0, 4)) - 2;
				// doubling mode searches twice the target, so aim at half
				if (knob_mse && $urandom_range(1))
					aim = aim / 2;
				if (aim < 1)
					aim = 1;
				if (aim > 64'hFFFF_FFFF)
					aim = 64'hFFFF_FFFF;
				tgt = aim;
			end
			5, 6: ;
			7: begin
				tgt = $urandom_range(1, 1000);
				par = $urandom_range(1, 100000);
			end
			8: begin
				tgt = extreme_value();
				par = extreme_value();
			end
			default: tgt = knob_thr + $urandom_range(0, 2) - 1;
		endcase
		if (tgt == 0)
			tgt = 1;
		if (par == 0)
			par = 1;
		send_item(tgt, par);
	endtask

	initial begin : stimulus
		int n, settings_left, waited;
		settings_left = 0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: linear search, 4-bit m, 2-bit p; field extremes, no candidate, exact hit
		send_item(32'd1, 32'd1);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'd1, 32'hFFFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'd1);
		send_item(32'd12000000, 32'd24000000);

		// writes to unused indexes must leave every register alone
		wait_idle();
		write_reg(CFG_SPARE_LO, {$urandom, $urandom});
		write_reg(CFG_SPARE_HI, {$urandom, $urandom});
		cfg_valid <= 1'b0;

		// no fields at all: parent passes through, mode is never flagged
		apply_settings(4'd0, 2'd0, 1'b0, '0, 1'b1, '0);
		send_item(32'd5, 32'd100);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// shift-only search at the widest shift field
		apply_settings(4'd0, 2'd3, 1'b0, '0, 1'b0, '0);
		send_item(32'd1000, 32'd100000);
		send_item(32'd1, 32'hFFFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'd1);

		// m field wider than honored, doubling around the threshold, 33-bit doubled target
		apply_settings(4'd15, 2'd3, 1'b0, '1, 1'b1, 32'h8000_0000);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'h8000_0000, 32'hFFFF_FFFF);
		send_item(32'd3, 32'd1000);

		// table ending at its fifth entry; first entry gives an exact hit for 120/5
		apply_settings(4'd1, 2'd1, 1'b1, 64'h0000_0003_01FF_0305, 1'b0, '1);
		send_item(32'd24, 32'd120);
		send_item(32'd1, 32'hFFFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// empty table: nothing is ever taken
		apply_settings(MFW_LIMIT, 2'd2, 1'b1, '0, 1'b0, '0);
		send_item(32'd100, 32'd1000);

		// full table, no shift, threshold at its top
		apply_settings(4'd4, 2'd0, 1'b1, 64'h0102_0304_0506_0708, 1'b1, '1);
		send_item(32'hFFFF_FFFF, 32'd100);
		send_item(32'd1000, 32'd3000);

		apply_settings(MFW_LIMIT, 2'd3, 1'b0, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0, '0);
		send_item(32'd3000000, 32'd24000000);
		send_item(32'd1, 32'd1);

		// random part in three idling phases, new settings every few dozen items
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				idle_pct = 69;
				stall_pct <= 22;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				idle_pct = 0;
				stall_pct <= 0;
			end
			if (settings_left == 0) begin
				random_settings();
				settings_left = $urandom_range(20, 60);
			end
			settings_left--;
			// long hold-off early on, while the sender keeps offering beats
			if (n == 5)
				holdoff_go <= 1'b1;
			send_random_item();
		end

		// drain, then give a stray beat time to show up
		in_valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (picks_waiting != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES)
			@(posedge clk);
		run_done <= 1'b1;
		repeat (2)
			@(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#100_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
src/clkdfs_pkg.sv
src/clkdfs_serial_div.sv
src/clkdfs_cand_eval.sv
src/clock_divider_factor_search_unit.sv
tb/sv/clock_divider_factor_search_checker.sv
tb/sv/clock_divider_factor_search_unit_tb.sv
